// ----- src/mlq_pkg.sv -----
// Shared types and constants for the multilevel queue task scheduler.
// No dependencies; every other file refers to it by scoped names.
package mlq_pkg;

   // service classes
   localparam logic [1:0] CLS_H = 2'd0;
   localparam logic [1:0] CLS_M = 2'd1;
   localparam logic [1:0] CLS_L = 2'd2;

   // input opcodes
   localparam logic OPC_ARRIVE = 1'b0;
   localparam logic OPC_TICK   = 1'b1;

   // queue commands
   typedef logic [1:0] q_op_type;
   localparam q_op_type OP_NOP   = 2'd0;
   localparam q_op_type OP_POP   = 2'd1;
   localparam q_op_type OP_PUSH  = 2'd2;
   localparam q_op_type OP_FRONT = 2'd3;

   // queue ordering keys
   localparam int KEY_PRI  = 0;
   localparam int KEY_REM  = 1;
   localparam int KEY_NONE = 2;

   // configuration registers
   localparam int CSR_AW = 1;
   localparam int CSR_DW = 6;
   localparam logic [CSR_AW-1:0] REG_H_QUANTUM = 1'd0;
   localparam logic [CSR_AW-1:0] REG_M_QUANTUM = 1'd1;
   localparam logic [5:0] H_QUANTUM_RST = 6'd6;
   localparam logic [5:0] M_QUANTUM_RST = 6'd4;

   // time slice: signed, all ones means no timeout
   localparam logic signed [6:0] SLICE_NONE = -7'sd1;

   typedef struct packed {
      logic [8:0] id;
      logic [5:0] rem;
      logic [3:0] pri;
   } entry_type;

   typedef struct packed {
      q_op_type  op;
      entry_type ent;
   } q_cmd_type;

   typedef struct packed {
      logic       opcode;
      logic [8:0] task_id;
      logic [1:0] task_class;
      logic [5:0] work_ticks;
      logic [3:0] task_priority;
   } req_type;

   typedef struct packed {
      logic        running_valid;
      logic [8:0]  running_id;
      logic [1:0]  running_class;
      logic        finished;
      logic [8:0]  finished_id;
      logic [15:0] finish_time;
      logic        queue_full;
      logic        all_idle;
   } rsp_type;

endpackage

// ----- src/mlq_cell.sv -----
// One queue slot: holds an entry and shifts with its neighbors.
// Depends on mlq_pkg.
module mlq_cell #(
   parameter int INDEX    = 0,
   parameter int CW       = 5,
   parameter int KEY_MODE = 0
) (
   input  logic               clock,
   input  mlq_pkg::q_cmd_type cmd,
   input  logic [CW-1:0]      count,
   input  mlq_pkg::entry_type left_ent,
   input  mlq_pkg::entry_type right_ent,
   input  logic               g_left,
   output logic               g_out,
   output mlq_pkg::entry_type ent_out
);

   mlq_pkg::entry_type ent_ff;
   mlq_pkg::entry_type ent_in;
   logic [5:0]         key_new;
   logic [5:0]         key_cur;
   logic               key_less;

   // compare the new entry against this slot
   always_comb begin
      if (KEY_MODE == mlq_pkg::KEY_PRI) begin
         key_new = {2'b00, cmd.ent.pri};
         key_cur = {2'b00, ent_ff.pri};
      end else begin
         key_new = cmd.ent.rem;
         key_cur = ent_ff.rem;
      end
      key_less = (KEY_MODE != mlq_pkg::KEY_NONE) && (key_new < key_cur);
      g_out = (cmd.op == mlq_pkg::OP_FRONT) || (count <= CW'(INDEX)) || key_less;
   end

   // shift right on insert, left on pop
   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         mlq_pkg::OP_POP: ent_in = right_ent;
         mlq_pkg::OP_PUSH, mlq_pkg::OP_FRONT: begin
            if (g_out) ent_in = g_left ? left_ent : cmd.ent;
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign ent_out = ent_ff;

endmodule

// ----- src/mlq_queue.sv -----
// One class queue: a row of mlq_cell slots plus its fill count.
// Depends on mlq_pkg and mlq_cell.
module mlq_queue #(
   parameter int DEPTH    = 16,
   parameter int KEY_MODE = 0,
   parameter int CW       = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  mlq_pkg::q_cmd_type cmd,
   output mlq_pkg::entry_type head,
   output logic [CW-1:0]      count
);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               full;
   mlq_pkg::q_cmd_type cell_cmd;
   mlq_pkg::entry_type ents [DEPTH];
   logic               g [DEPTH];

   assign full = (count_ff >= CW'(DEPTH));

   // update the fill count; drop pushes into a full row
   always_comb begin
      cell_cmd = cmd;
      count_in = count_ff;
      case (cmd.op)
         mlq_pkg::OP_POP: begin
            if (count_ff != '0) count_in = count_ff - 1'b1;
         end
         mlq_pkg::OP_PUSH, mlq_pkg::OP_FRONT: begin
            if (full) cell_cmd.op = mlq_pkg::OP_NOP;
            else count_in = count_ff + 1'b1;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mlq_cell #(
         .INDEX(i),
         .CW(CW),
         .KEY_MODE(KEY_MODE)
      ) u_cell (
         .clock(clock),
         .cmd(cell_cmd),
         .count(count_ff),
         .left_ent((i == 0) ? cmd.ent : ents[(i == 0) ? 0 : i - 1]),
         .right_ent(ents[(i == DEPTH - 1) ? i : i + 1]),
         .g_left((i == 0) ? 1'b0 : g[(i == 0) ? 0 : i - 1]),
         .g_out(g[i]),
         .ent_out(ents[i])
      );
   end

   assign head  = ents[0];
   assign count = count_ff;

endmodule

// ----- src/multilevel_queue_task_scheduler_unit.sv -----
// Multilevel queue task scheduler, top level. Depends on mlq_pkg and mlq_queue.
// An item passes through four steps inside: execute, two insert steps, respond; rsp_strobe
// is high in the respond step. A new item is taken at the earliest in the respond step, so
// the unit takes no new item before the last is through. The insert steps are set by the one
// shift per cycle that each cell row of a queue can make.
// Synchronous reset empties all queues, stops the running task, serves class L, no timeout.
// The receiver cannot stall: each result shows for one cycle.
module multilevel_queue_task_scheduler_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  mlq_pkg::req_type             req_data,
   output logic                         rsp_strobe,
   output mlq_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [mlq_pkg::CSR_AW-1:0]   csr_index,
   input  logic [mlq_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_INS1 = 3'd2;
   localparam logic [2:0] S_INS2 = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]               state_ff, state_in;
   mlq_pkg::req_type         req_ff;
   logic [5:0]               hq_ff, mq_ff;
   logic                     run_valid_ff, run_valid_in;
   mlq_pkg::entry_type       run_ff, run_in;
   logic [1:0]               serve_ff, serve_in;
   logic signed [6:0]        slice_ff, slice_in;
   logic [15:0]              tick_ff, tick_in;
   logic                     pend1_ff, pend1_in;
   mlq_pkg::entry_type       pend1_ent_ff, pend1_ent_in;
   logic                     pend2_ff, pend2_in;
   mlq_pkg::rsp_type         res_ff, res_in;

   mlq_pkg::q_cmd_type       h_cmd, m_cmd, l_cmd;
   mlq_pkg::entry_type       h_head, m_head, l_head;
   logic [CW-1:0]            h_cnt, m_cnt, l_cnt;

   logic                     accept, tick;
   logic                     h_any, m_any, l_any, h_full, m_full, l_full;
   logic                     take_h, take_m, take_l, load, preempt_h, preempt_l;
   logic                     cur_valid, finish, timeout, own_full;
   mlq_pkg::entry_type       cur;
   logic [1:0]               cls2;
   logic signed [6:0]        slice2, slice3;
   logic                     all_idle;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE) && (state_ff != S_RESP);
   assign tick   = (req_ff.opcode == mlq_pkg::OPC_TICK);

   assign h_any  = (h_cnt != '0);
   assign m_any  = (m_cnt != '0);
   assign l_any  = (l_cnt != '0);
   assign h_full = (h_cnt >= CW'(QUEUE_DEPTH));
   assign m_full = (m_cnt >= CW'(QUEUE_DEPTH));
   assign l_full = (l_cnt >= CW'(QUEUE_DEPTH));

   // pick or preempt, then run one unit
   always_comb begin
      take_h    = 1'b0;
      take_m    = 1'b0;
      take_l    = 1'b0;
      load      = 1'b0;
      preempt_h = 1'b0;
      preempt_l = 1'b0;
      if (!run_valid_ff) begin
         case (serve_ff)
            mlq_pkg::CLS_H: begin
               if (h_any) take_h = 1'b1;
               else if (m_any) begin take_m = 1'b1; load = 1'b1; end
               else if (l_any) begin take_l = 1'b1; load = 1'b1; end
            end
            mlq_pkg::CLS_M: begin
               if (m_any) take_m = 1'b1;
               else if (h_any) begin take_h = 1'b1; load = 1'b1; end
               else if (l_any) begin take_l = 1'b1; load = 1'b1; end
            end
            default: begin
               load = 1'b1;
               if (h_any) take_h = 1'b1;
               else if (m_any) take_m = 1'b1;
               else if (l_any) take_l = 1'b1;
            end
         endcase
      end else if (serve_ff == mlq_pkg::CLS_H) begin
         preempt_h = h_any && (h_head.pri < run_ff.pri);
      end else if (serve_ff == mlq_pkg::CLS_L) begin
         preempt_l = (h_any || m_any) && !l_full;
         take_h    = preempt_l && h_any;
         take_m    = preempt_l && !h_any;
         load      = preempt_l;
      end

      cur_valid = run_valid_ff || take_h || take_m || take_l;
      if (take_h || preempt_h) cur = h_head;
      else if (take_m) cur = m_head;
      else if (take_l) cur = l_head;
      else cur = run_ff;

      cls2   = serve_ff;
      slice2 = slice_ff;
      if (load) begin
         if (take_h) begin
            cls2 = mlq_pkg::CLS_H; slice2 = $signed({1'b0, hq_ff});
         end else if (take_m) begin
            cls2 = mlq_pkg::CLS_M; slice2 = $signed({1'b0, mq_ff});
         end else if (take_l) begin
            cls2 = mlq_pkg::CLS_L; slice2 = mlq_pkg::SLICE_NONE;
         end
      end

      finish = cur_valid && (cur.rem <= 6'd1);
      if (cur_valid && (slice2 != mlq_pkg::SLICE_NONE)) slice3 = slice2 - 7'sd1;
      else slice3 = slice2;
      timeout = cur_valid && !finish && (slice3 == 7'sd0) && (cls2 != mlq_pkg::CLS_L);
   end

   // full check for the timeout requeue
   always_comb begin
      case (serve_ff)
         mlq_pkg::CLS_H: own_full = h_full;
         mlq_pkg::CLS_M: own_full = m_full;
         default:        own_full = l_full;
      endcase
   end

   // drive the queue rows
   always_comb begin
      h_cmd = '{op: mlq_pkg::OP_NOP, ent: run_ff};
      m_cmd = '{op: mlq_pkg::OP_NOP, ent: run_ff};
      l_cmd = '{op: mlq_pkg::OP_NOP, ent: run_ff};
      case (state_ff)
         S_EXEC: begin
            if (tick) begin
               if (take_h || preempt_h) h_cmd.op = mlq_pkg::OP_POP;
               if (take_m) m_cmd.op = mlq_pkg::OP_POP;
               if (take_l) l_cmd.op = mlq_pkg::OP_POP;
               if (preempt_l) l_cmd.op = mlq_pkg::OP_FRONT;
            end
         end
         S_INS1: begin
            if (pend1_ff) begin
               h_cmd.op  = mlq_pkg::OP_PUSH;
               h_cmd.ent = pend1_ent_ff;
            end else if (!tick) begin
               h_cmd.ent = '{id: req_ff.task_id, rem: req_ff.work_ticks,
                             pri: req_ff.task_priority};
               m_cmd.ent = h_cmd.ent;
               l_cmd.ent = h_cmd.ent;
               case (req_ff.task_class)
                  mlq_pkg::CLS_H: h_cmd.op = mlq_pkg::OP_PUSH;
                  mlq_pkg::CLS_M: m_cmd.op = mlq_pkg::OP_PUSH;
                  mlq_pkg::CLS_L: l_cmd.op = mlq_pkg::OP_PUSH;
                  default: h_cmd.op = mlq_pkg::OP_NOP;
               endcase
            end
         end
         S_INS2: begin
            if (pend2_ff && !own_full) begin
               if (serve_ff == mlq_pkg::CLS_H) h_cmd.op = mlq_pkg::OP_PUSH;
               else m_cmd.op = mlq_pkg::OP_PUSH;
            end
         end
         default: h_cmd.op = mlq_pkg::OP_NOP;
      endcase
   end

   // sequence one item
   always_comb begin
      state_in     = state_ff;
      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      serve_in     = serve_ff;
      slice_in     = slice_ff;
      tick_in      = tick_ff;
      pend1_in     = pend1_ff;
      pend1_ent_in = pend1_ent_ff;
      pend2_in     = pend2_ff;
      res_in       = res_ff;
      case (state_ff)
         S_IDLE, S_RESP: begin
            state_in = accept ? S_EXEC : S_IDLE;
         end
         S_EXEC: begin
            state_in     = S_INS1;
            res_in       = '0;
            pend1_in     = 1'b0;
            pend2_in     = 1'b0;
            pend1_ent_in = run_ff;
            if (tick) begin
               pend1_in     = preempt_h;
               pend2_in     = timeout;
               run_valid_in = cur_valid && !finish;
               run_in       = '{id: cur.id, rem: cur.rem - 6'd1, pri: cur.pri};
               serve_in     = cls2;
               slice_in     = slice3;
               tick_in      = tick_ff + 16'd1;
               res_in.running_valid = cur_valid;
               res_in.running_id    = cur_valid ? cur.id : 9'd0;
               res_in.running_class = cls2;
               res_in.finished      = finish;
               res_in.finished_id   = finish ? cur.id : 9'd0;
               res_in.finish_time   = finish ? tick_ff + 16'd1 : 16'd0;
            end
         end
         S_INS1: begin
            state_in = S_INS2;
            if (!pend1_ff && !tick) begin
               case (req_ff.task_class)
                  mlq_pkg::CLS_H: res_in.queue_full = h_full;
                  mlq_pkg::CLS_M: res_in.queue_full = m_full;
                  mlq_pkg::CLS_L: res_in.queue_full = l_full;
                  default: res_in.queue_full = 1'b0;
               endcase
            end
         end
         S_INS2: begin
            state_in = S_RESP;
            if (pend2_ff) begin
               if (own_full) begin
                  slice_in = (serve_ff == mlq_pkg::CLS_H) ? $signed({1'b0, hq_ff})
                                                          : $signed({1'b0, mq_ff});
               end else begin
                  run_valid_in = 1'b0;
                  if (serve_ff == mlq_pkg::CLS_H) begin
                     serve_in = mlq_pkg::CLS_M;
                     slice_in = $signed({1'b0, mq_ff});
                  end else begin
                     serve_in = mlq_pkg::CLS_H;
                     slice_in = $signed({1'b0, hq_ff});
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_valid_ff <= 1'b0;
         serve_ff     <= mlq_pkg::CLS_L;
         slice_ff     <= mlq_pkg::SLICE_NONE;
         tick_ff      <= '0;
         pend1_ff     <= 1'b0;
         pend2_ff     <= 1'b0;
         hq_ff        <= mlq_pkg::H_QUANTUM_RST;
         mq_ff        <= mlq_pkg::M_QUANTUM_RST;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         serve_ff     <= serve_in;
         slice_ff     <= slice_in;
         tick_ff      <= tick_in;
         pend1_ff     <= pend1_in;
         pend2_ff     <= pend2_in;
         if (csr_we && (csr_index == mlq_pkg::REG_H_QUANTUM)) hq_ff <= csr_wdata;
         if (csr_we && (csr_index == mlq_pkg::REG_M_QUANTUM)) mq_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      run_ff       <= run_in;
      pend1_ent_ff <= pend1_ent_in;
      res_ff       <= res_in;
   end

   mlq_queue #(.DEPTH(QUEUE_DEPTH), .KEY_MODE(mlq_pkg::KEY_PRI)) u_hq (
      .clock(clock), .reset(reset), .cmd(h_cmd), .head(h_head), .count(h_cnt)
   );
   mlq_queue #(.DEPTH(QUEUE_DEPTH), .KEY_MODE(mlq_pkg::KEY_REM)) u_mq (
      .clock(clock), .reset(reset), .cmd(m_cmd), .head(m_head), .count(m_cnt)
   );
   mlq_queue #(.DEPTH(QUEUE_DEPTH), .KEY_MODE(mlq_pkg::KEY_NONE)) u_lq (
      .clock(clock), .reset(reset), .cmd(l_cmd), .head(l_head), .count(l_cnt)
   );

   // present the result
   assign all_idle   = !run_valid_ff && !h_any && !m_any && !l_any;
   assign rsp_strobe = (state_ff == S_RESP);
   always_comb begin
      rsp_data          = res_ff;
      rsp_data.all_idle = all_idle;
   end

   // checks
   a_resp_after_ins2: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_INS2))
      else $error("result without insert steps");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (h_cnt <= CW'(QUEUE_DEPTH)) && (m_cnt <= CW'(QUEUE_DEPTH))
      && (l_cnt <= CW'(QUEUE_DEPTH)))
      else $error("queue count past depth");
   a_finish_runs: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.finished) |-> rsp_data.running_valid)
      else $error("finish without running task");
   a_full_on_arrival: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.queue_full) |-> (req_ff.opcode == mlq_pkg::OPC_ARRIVE))
      else $error("queue full flagged on tick");
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS1 && (pend1_ff || pend2_ff)) |-> tick)
      else $error("requeue pending on arrival");

endmodule
